// ----- sv/shgd_pkg.sv -----
package shgd_pkg;

  localparam int HEAT_W   = 15;
  localparam int PIX_W    = 16;
  localparam int ADD_W    = 16;
  localparam int DECAY_W  = 23;
  localparam int FRAC_W   = 8;
  localparam int CS_W     = 7;
  localparam int DIM_W    = 9;
  localparam int LIM_W    = 13;
  localparam int CFG_IDX_W = 2;

  // quotient bits retired per divider cycle
  localparam int DIV_BITS = 4;

  localparam logic [HEAT_W-1:0] HEAT_CAP       = 15'd32700;
  localparam logic [CS_W-1:0]   CELL_SIZE_RST  = 7'd4;
  localparam logic [DIM_W-1:0]  COLUMNS_RST    = 9'd192;
  localparam logic [DIM_W-1:0]  ROWS_RST       = 9'd192;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DECAY = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE = 2'd0,
    CFG_COLUMNS   = 2'd1,
    CFG_ROWS      = 2'd2
  } cfg_e;

endpackage

// ----- sv/shgd_ram.sv -----
module shgd_ram import shgd_pkg::*; #(
  parameter int AW = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [HEAT_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [HEAT_W-1:0] rdata_o
);

  logic [HEAT_W-1:0] heat_mem [2**AW];
  logic [HEAT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      heat_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= heat_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/shgd_div.sv -----
module shgd_div import shgd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PIX_W-1:0] dividend_i,
  input  logic [CS_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [PIX_W-1:0] quotient_o
);

  localparam int STEPS = PIX_W / DIV_BITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CS_W-1:0]  rem_q, rem_d;
  logic [CS_W-1:0]  div_q, div_d;
  logic [PIX_W-1:0] work_q, work_d;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [CS_W:0]    t;
    logic [CS_W-1:0]  r;
    logic [PIX_W-1:0] w;
    r      = rem_q;
    w      = work_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, w[PIX_W-1]};
      w = {w[PIX_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t    = t - {1'b0, div_q};
        w[0] = 1'b1;
      end
      r = t[CS_W-1:0];
    end
    rem_d  = r;
    work_d = w;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      work_d = dividend_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else begin
      rem_d  = rem_q;
      work_d = work_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    work_q <= work_d;
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// ----- sv/saturating_heat_grid_with_decay.sv -----
// Heat grid of MAX_ROWS x MAX_COLUMNS cells (0..32700) held in one single-port-read,
// single-port-write RAM. After reset the block runs a clearing pass over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) words (65536 with the defaults) with
// in_stall_o high. An add or read request passes through the pair of radix-16
// dividers (one per axis) that map pixels to cells, then address, RAM read,
// modify/write-back and result hand-off. A decay request sweeps the used
// rows_in_use x columns_in_use area at one cell per cycle through the RAM read/write
// pipeline, then a drain step and result hand-off. One request is in flight at a time;
// a finished result sits in the output register while the next request is taken.
module saturating_heat_grid_with_decay import shgd_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [PIX_W-1:0]     x_pixel_i,
  input  logic [PIX_W-1:0]     y_pixel_i,
  input  logic [ADD_W-1:0]     add_value_i,
  input  logic [DECAY_W-1:0]   decay_amount_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [HEAT_W-1:0]    heat_o
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = CW + RW;
  localparam logic [LIM_W-1:0] MAX_COL_L = LIM_W'(MAX_COLUMNS);
  localparam logic [LIM_W-1:0] MAX_ROW_L = LIM_W'(MAX_ROWS);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_MOD   = 8'b0001_0000,
    ST_SWEEP = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CS_W-1:0]     cs_q, cs_d;
  logic [DIM_W-1:0]    cols_q, cols_d;
  logic [DIM_W-1:0]    rows_q, rows_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                wb_v_q, wb_v_d;
  logic                out_valid_q, out_valid_d;

  cmd_e                cmd_q, cmd_d;
  logic [ADD_W-1:0]    add_q, add_d;
  logic [DECAY_W-1:0]  decay_q, decay_d;
  logic                x_neg_q, x_neg_d;
  logic                y_neg_q, y_neg_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [AW-1:0]       wb_addr_q, wb_addr_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [HEAT_W-1:0]   res_q, res_d;
  logic [HEAT_W-1:0]   heat_q, heat_d;

  logic                accept;
  logic                div_start;
  logic [CS_W-1:0]     cs_eff;
  logic [LIM_W-1:0]    cols_l, rows_l;
  logic [CW-1:0]       last_col;
  logic [RW-1:0]       last_row;
  logic                x_done, y_done;
  logic [PIX_W-1:0]    x_quo, y_quo;
  logic [CW-1:0]       col_c;
  logic [RW-1:0]       row_c;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [HEAT_W-1:0]   mem_wdata, mem_rdata;

  logic [HEAT_W+1:0]   sum;
  logic [HEAT_W-1:0]   sum_sat;
  logic [DECAY_W-1:0]  scaled, diff;
  logic [HEAT_W-1:0]   decayed;
  logic                load_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign div_start   = accept && ((cmd_e'(cmd_i) == CMD_ADD) || (cmd_e'(cmd_i) == CMD_READ));

  assign cs_eff = (cs_q == '0) ? CS_W'(1) : cs_q;
  assign cols_l = LIM_W'(cols_q);
  assign rows_l = LIM_W'(rows_q);

  always_comb begin
    if (cols_q == '0) begin
      last_col = '0;
    end else if (cols_l > MAX_COL_L) begin
      last_col = CW'(MAX_COL_L - LIM_W'(1));
    end else begin
      last_col = CW'(cols_l - LIM_W'(1));
    end
    if (rows_q == '0) begin
      last_row = '0;
    end else if (rows_l > MAX_ROW_L) begin
      last_row = RW'(MAX_ROW_L - LIM_W'(1));
    end else begin
      last_row = RW'(rows_l - LIM_W'(1));
    end
  end

  shgd_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, x_pixel_i[PIX_W-2:0]}),
    .divisor_i  (cs_eff),
    .done_o     (x_done),
    .quotient_o (x_quo)
  );

  shgd_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, y_pixel_i[PIX_W-2:0]}),
    .divisor_i  (cs_eff),
    .done_o     (y_done),
    .quotient_o (y_quo)
  );

  // negative pixels truncate toward zero and clamp to cell 0
  always_comb begin
    if (x_neg_q) begin
      col_c = '0;
    end else if (x_quo > PIX_W'(last_col)) begin
      col_c = last_col;
    end else begin
      col_c = x_quo[CW-1:0];
    end
    if (y_neg_q) begin
      row_c = '0;
    end else if (y_quo > PIX_W'(last_row)) begin
      row_c = last_row;
    end else begin
      row_c = y_quo[RW-1:0];
    end
  end

  always_comb begin
    sum = {2'b00, mem_rdata} + {add_q[ADD_W-1], add_q};
    if (sum[HEAT_W+1]) begin
      sum_sat = '0;
    end else if (sum[HEAT_W:0] > (HEAT_W+1)'(HEAT_CAP)) begin
      sum_sat = HEAT_CAP;
    end else begin
      sum_sat = sum[HEAT_W-1:0];
    end
    scaled  = {mem_rdata, {FRAC_W{1'b0}}};
    diff    = scaled - decay_q;
    decayed = (scaled > decay_q) ? diff[DECAY_W-1:FRAC_W] : '0;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_addr_q;
    mem_wdata = decayed;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (wb_v_q) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_q;
      mem_wdata = decayed;
    end else if ((state_q == ST_MOD) && (cmd_q == CMD_ADD)) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = sum_sat;
    end
    if (state_q == ST_READ) begin
      mem_re = 1'b1;
    end else if (state_q == ST_SWEEP) begin
      mem_re    = 1'b1;
      mem_raddr = {row_q, col_q};
    end
  end

  shgd_ram #(
    .AW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cs_d      = cs_q;
    cols_d    = cols_q;
    rows_d    = rows_q;
    clr_d     = clr_q;
    wb_v_d    = 1'b0;
    cmd_d     = cmd_q;
    add_d     = add_q;
    decay_d   = decay_q;
    x_neg_d   = x_neg_q;
    y_neg_d   = y_neg_q;
    addr_d    = addr_q;
    wb_addr_d = wb_addr_q;
    row_d     = row_q;
    col_d     = col_q;
    res_d     = res_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_e'(cfg_index_i))
        CFG_CELL_SIZE: cs_d   = cfg_data_i[CS_W-1:0];
        CFG_COLUMNS:   cols_d = cfg_data_i;
        CFG_ROWS:      rows_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_e'(cmd_i);
          add_d   = add_value_i;
          decay_d = decay_amount_i;
          x_neg_d = x_pixel_i[PIX_W-1];
          y_neg_d = y_pixel_i[PIX_W-1];
          case (cmd_e'(cmd_i))
            CMD_ADD, CMD_READ: state_d = ST_DIV;
            CMD_DECAY: begin
              row_d   = '0;
              col_d   = '0;
              state_d = ST_SWEEP;
            end
            default: begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (x_done) begin
          addr_d  = {row_c, col_c};
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        res_d   = (cmd_q == CMD_ADD) ? sum_sat : mem_rdata;
        state_d = ST_DONE;
      end
      ST_SWEEP: begin
        wb_v_d    = 1'b1;
        wb_addr_d = {row_q, col_q};
        if (col_q == last_col) begin
          col_d = '0;
          row_d = row_q + RW'(1);
          if (row_q == last_row) begin
            state_d = ST_DRAIN;
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        res_d   = '0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
      heat_d      = res_q;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
      heat_d      = heat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cs_q        <= CELL_SIZE_RST;
      cols_q      <= COLUMNS_RST;
      rows_q      <= ROWS_RST;
      clr_q       <= '0;
      wb_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      clr_q       <= clr_d;
      wb_v_q      <= wb_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    add_q     <= add_d;
    decay_q   <= decay_d;
    x_neg_q   <= x_neg_d;
    y_neg_q   <= y_neg_d;
    addr_q    <= addr_d;
    wb_addr_q <= wb_addr_d;
    row_q     <= row_d;
    col_q     <= col_d;
    res_q     <= res_d;
    heat_q    <= heat_d;
  end

  assign out_valid_o = out_valid_q;
  assign heat_o      = heat_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done |-> y_done)
    else $error("divider lanes out of step");

  a_sweep_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_v_q && (state_q == ST_SWEEP)) |-> (wb_addr_q != mem_raddr))
    else $error("decay write-back collides with read");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> !wb_v_q)
    else $error("add write-back overlaps decay write-back");

  a_decay_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (cmd_q == CMD_DECAY)) |-> (res_q == '0))
    else $error("decay result not zero");

  a_heat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heat_o <= HEAT_CAP))
    else $error("heat above cap");

endmodule
